>>> src/fsel_pkg.sv
// shared types, codes and constants of the fifo shared/exclusive lock unit
package fsel_pkg;

   // default sizes handed to the top level
   localparam int unsigned DEF_QUEUE_DEPTH = 16;
   localparam int unsigned DEF_TAG_BITS    = 8;
   localparam int unsigned DEF_MAX_HOLDERS = 256;

   // most queue grants made by one release
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned DRAIN_BITS  = $clog2(MAX_RESULTS + 1);

   // request operation codes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [1:0] RSP_GRANT_NOW   = 2'd0;
   localparam logic [1:0] RSP_GRANT_QUEUE = 2'd1;
   localparam logic [1:0] RSP_REJECT_FULL = 2'd2;
   localparam logic [1:0] RSP_NO_HOLDER   = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic acq_grant;
      logic acq_reject;
      logic acq_enqueue;
      logic rel_fault;
      logic rel_dec;
      logic drain_grant;
      logic drain_finish;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_release;
      logic acq_now;
      logic queue_full;
      logic count_zero;
      logic drain_ok;
   } dp_status_type;

endpackage

>>> src/fifo_shared_exclusive_lock_unit.sv
// top level of the fifo shared/exclusive lock unit: controller plus datapath
// acquire or release without holder: busy during the decide step, result strobe in the cycle
//   after that step; the next beat is accepted only once the unit is idle again
// release with holders: a decide step, a drain step per queue grant (read port sets the pace),
//   a step to close the drain; strobes one per cycle, the last in the cycle after the close
// synchronous reset empties the queue and clears holders; results are never stalled
module fifo_shared_exclusive_lock_unit #(
   parameter int unsigned QUEUE_DEPTH = fsel_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned TAG_BITS    = fsel_pkg::DEF_TAG_BITS,
   parameter int unsigned MAX_HOLDERS = fsel_pkg::DEF_MAX_HOLDERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_op,
   input  logic [TAG_BITS-1:0] req_task_tag,
   input  logic                req_want_shared,
   input  logic                req_has_parent,
   output logic                rsp_valid,
   output logic [TAG_BITS-1:0] rsp_grant_tag,
   output logic                rsp_grant_shared,
   output logic                rsp_route_parent,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);
   import fsel_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencing
   fsel_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (cmd)
   );

   // lock state and queue
   fsel_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .MAX_HOLDERS (MAX_HOLDERS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (dp_status),
      .req_op           (req_op),
      .req_task_tag     (req_task_tag),
      .req_want_shared  (req_want_shared),
      .req_has_parent   (req_has_parent),
      .rsp_valid        (rsp_valid),
      .rsp_grant_tag    (rsp_grant_tag),
      .rsp_grant_shared (rsp_grant_shared),
      .rsp_route_parent (rsp_route_parent),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

>>> src/fsel_ctrl.sv
// controller state machine of the lock unit: sequences decide and drain steps
module fsel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fsel_pkg::dp_status_type status,
   output fsel_pkg::ctrl_cmd_type  cmd
);
   import fsel_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!status.is_release) begin
               if (status.acq_now) begin
                  cmd.acq_grant = 1'b1;
               end else if (status.queue_full) begin
                  cmd.acq_reject = 1'b1;
               end else begin
                  cmd.acq_enqueue = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (status.count_zero) begin
               cmd.rel_fault = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.rel_dec = 1'b1;
               state_in    = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.drain_ok) begin
               cmd.drain_grant = 1'b1;
            end else begin
               cmd.drain_finish = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // decide step only follows an accepted beat
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $past(start && state_ff == ST_IDLE))
      else $error("decide step without accepted beat");

   // drain only entered from a release decision or itself
   a_drain_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> $past(state_ff == ST_EXEC || state_ff == ST_DRAIN))
      else $error("drain entered from idle");

endmodule

>>> src/fsel_dpath.sv
// datapath of the lock unit: holder count, wait queue memory and result registers
module fsel_dpath #(
   parameter int unsigned QUEUE_DEPTH = fsel_pkg::DEF_QUEUE_DEPTH,
   parameter int unsigned TAG_BITS    = fsel_pkg::DEF_TAG_BITS,
   parameter int unsigned MAX_HOLDERS = fsel_pkg::DEF_MAX_HOLDERS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fsel_pkg::ctrl_cmd_type  cmd,
   output fsel_pkg::dp_status_type status,
   input  logic                   req_op,
   input  logic [TAG_BITS-1:0]    req_task_tag,
   input  logic                   req_want_shared,
   input  logic                   req_has_parent,
   output logic                   rsp_valid,
   output logic [TAG_BITS-1:0]    rsp_grant_tag,
   output logic                   rsp_grant_shared,
   output logic                   rsp_route_parent,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);
   import fsel_pkg::*;

   localparam int unsigned CW = $clog2(MAX_HOLDERS + 1);
   localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0] HOLD_LIMIT = CW'(MAX_HOLDERS);
   localparam logic [FW-1:0] FILL_LIMIT = FW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] PTR_LAST   = PW'(QUEUE_DEPTH - 1);
   localparam logic [DRAIN_BITS-1:0] DRAIN_LIMIT = DRAIN_BITS'(MAX_RESULTS);

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                sh;
      logic                par;
   } entry_type;

   // captured request
   logic                op_ff;
   entry_type           req_ff;

   // lock state
   logic [CW-1:0]         count_ff, count_in;
   logic                  hshared_ff, hshared_in;
   logic [PW-1:0]         head_ff, head_in;
   logic [PW-1:0]         tail_ff, tail_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [DRAIN_BITS-1:0] dcnt_ff, dcnt_in;

   // pending queue grant, held until the next drain decision tells its last bit
   entry_type pend_ff;
   logic      pend_valid_ff, pend_valid_in;

   // wait queue memory and its registered head read
   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   // result registers
   logic      rsp_valid_ff, rsp_valid_in;
   entry_type rsp_entry_ff, rsp_entry_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic      rsp_last_ff, rsp_last_in;

   // decisions
   always_comb begin
      status.is_release = (op_ff == OP_RELEASE);
      status.count_zero = (count_ff == '0);
      status.acq_now    = (count_ff < HOLD_LIMIT) &&
                          ((count_ff == '0) ||
                           (req_ff.sh && hshared_ff && (fill_ff == '0)));
      status.queue_full = (fill_ff >= FILL_LIMIT);
      status.drain_ok   = (dcnt_ff < DRAIN_LIMIT) && (fill_ff != '0) &&
                          (count_ff < HOLD_LIMIT) &&
                          ((count_ff == '0) || (rd_ff.sh && hshared_ff));
   end

   // state updates
   always_comb begin
      count_in      = count_ff;
      hshared_in    = hshared_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      dcnt_in       = dcnt_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.acq_grant) begin
         count_in   = count_ff + CW'(1);
         hshared_in = req_ff.sh;
      end
      if (cmd.acq_enqueue) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PW'(1);
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.rel_dec) begin
         count_in      = count_ff - CW'(1);
         dcnt_in       = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.drain_grant) begin
         head_in       = (head_ff == PTR_LAST) ? '0 : head_ff + PW'(1);
         fill_in       = fill_ff - FW'(1);
         count_in      = count_ff + CW'(1);
         hshared_in    = rd_ff.sh;
         dcnt_in       = dcnt_ff + DRAIN_BITS'(1);
         pend_valid_in = 1'b1;
      end
      if (cmd.drain_finish) begin
         pend_valid_in = 1'b0;
      end
   end

   // result selection
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_entry_in  = req_ff;
      rsp_status_in = RSP_GRANT_NOW;
      rsp_last_in   = 1'b1;
      if (cmd.acq_grant) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.acq_reject) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = RSP_REJECT_FULL;
      end else if (cmd.rel_fault) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = '0;
         rsp_status_in = RSP_NO_HOLDER;
      end else if ((cmd.drain_grant || cmd.drain_finish) && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = pend_ff;
         rsp_status_in = RSP_GRANT_QUEUE;
         rsp_last_in   = cmd.drain_finish;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         hshared_ff    <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fill_ff       <= '0;
         dcnt_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         hshared_ff    <= hshared_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fill_ff       <= fill_in;
         dcnt_ff       <= dcnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         req_ff.tag <= req_task_tag;
         req_ff.sh  <= req_want_shared;
         req_ff.par <= req_has_parent;
      end
      if (cmd.drain_grant) begin
         pend_ff <= rd_ff;
      end
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // wait queue memory: write at tail, read at the next head
   always_ff @(posedge clock) begin
      if (cmd.acq_enqueue) begin
         mem[tail_ff] <= req_ff;
      end
      rd_ff <= mem[head_in];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_grant_tag    = rsp_entry_ff.tag;
   assign rsp_grant_shared = rsp_entry_ff.sh;
   assign rsp_route_parent = rsp_entry_ff.par;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // queue fill stays within depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_LIMIT)
      else $error("queue fill beyond depth");

   // empty queue has aligned pointers
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with head and tail apart");

   // a held queue grant goes out as the final beat when the drain ends
   a_pend_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.drain_finish && pend_valid_ff |=> rsp_valid_ff && rsp_last_ff)
      else $error("pending grant lost at end of drain");

endmodule
